/* rtl/vbc_pkg.sv */
`default_nettype none

package vbc_pkg;

  localparam int KEY_DEPTH_DEF = 64;

  localparam int BYTE_W = 8;
  localparam int SLOT_W = 6;
  localparam int LEN_W = 7;
  localparam int SHIFT_W = 5;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic REQ_TEXT = 1'b0;
  localparam logic REQ_KEY = 1'b1;

  localparam logic [PADDR_W-3:0] REG_KEY_LENGTH = '0;
  localparam logic [LEN_W-1:0] KEY_LENGTH_RESET = 7'd1;

  localparam logic [BYTE_W-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [BYTE_W-1:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [BYTE_W-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [BYTE_W-1:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [BYTE_W-1:0] CYR_FIRST = 8'hC0;

  localparam logic [SHIFT_W:0] LATIN_SIZE = 6'd26;

  function automatic logic is_neutral(input logic [BYTE_W-1:0] b);
    logic hit;
    case (b)
      8'h20, 8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h2A, 8'h2B,
      8'h2C, 8'h2D, 8'h2E, 8'h2F, 8'h3D, 8'h3F, 8'h40, 8'h5E,
      8'h5F, 8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
      8'h37, 8'h38, 8'h39: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  function automatic logic [SHIFT_W-1:0] key_shift_of(input logic [BYTE_W-1:0] b);
    logic [SHIFT_W-1:0] s;
    if (b >= CHAR_LOWER_A && b <= CHAR_LOWER_Z) begin
      s = SHIFT_W'(b - CHAR_LOWER_A);
    end else if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) begin
      s = SHIFT_W'(b - CHAR_UPPER_A);
    end else if (b >= CYR_FIRST) begin
      s = b[SHIFT_W-1:0];
    end else begin
      s = '0;
    end
    return s;
  endfunction

  // Adds a shift to a Latin letter offset, both reduced modulo 26.
  function automatic logic [SHIFT_W-1:0] latin_add(input logic [SHIFT_W-1:0] ofs,
                                                   input logic [SHIFT_W-1:0] shift);
    logic [SHIFT_W:0] s;
    logic [SHIFT_W:0] sum;
    s = {1'b0, shift};
    if (s >= LATIN_SIZE) begin
      s = s - LATIN_SIZE;
    end
    sum = {1'b0, ofs} + s;
    if (sum >= LATIN_SIZE) begin
      sum = sum - LATIN_SIZE;
    end
    return sum[SHIFT_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/vbc_req_if.sv */
`default_nettype none

interface vbc_req_if import vbc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [BYTE_W-1:0] data_byte;
  logic [SLOT_W-1:0] key_slot;
  logic              message_start;

  modport source (output valid, req_type, data_byte, key_slot, message_start, input ready);
  modport sink (input valid, req_type, data_byte, key_slot, message_start, output ready);
endinterface

`default_nettype wire

/* rtl/vbc_res_if.sv */
`default_nettype none

interface vbc_res_if import vbc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] cipher_byte;
  logic              was_letter;

  modport source (output valid, cipher_byte, was_letter, input ready);
  modport sink (input valid, cipher_byte, was_letter, output ready);
endinterface

`default_nettype wire

/* rtl/vbc_ram.sv */
`default_nettype none

module vbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/vigenere_byte_cipher_core.sv */
// Vigenere byte cipher core.
// The req channel carries one word per byte: a key write (req_type set) stores the
// case-folded alphabet position of data_byte in key slot key_slot and gives no result;
// a text byte (req_type clear) gives one word on the res channel with the enciphered
// byte and a flag that tells whether it was a letter and was shifted.
// message_start on a text byte restarts the key at slot zero.
// key_length is written over APB at byte address 0; the user writes it only while the core is idle (not enforced).
// A text byte accepted on req passes through the key store read stage and then the
// modular add into the output register before it leaves on res.
// A word can be accepted in every cycle while res is not stalled; the single key store
// read per text byte and the add that follows it set that rate.
// Reset clears the key position, sets key_length to one and empties the pipeline.
// The key store is not cleared, so every slot in use must be written before text.
// When res is stalled, one more text byte is taken into the read stage and req then
// deasserts ready until the output register drains.
`default_nettype none

module vigenere_byte_cipher_core import vbc_pkg::*; #(
  parameter int KEY_DEPTH = KEY_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  vbc_req_if.sink                 req,
  vbc_res_if.source               res,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready
);

  localparam int AddrW = KEY_DEPTH > 1 ? $clog2(KEY_DEPTH) : 1;
  localparam int LenMax = (1 << LEN_W) - 1;
  localparam int EffMax = KEY_DEPTH < LenMax ? KEY_DEPTH : LenMax;
  localparam int PosW = EffMax > 1 ? $clog2(EffMax) : 1;

  logic [LEN_W-1:0]  key_length;
  logic [LEN_W-1:0]  eff_len;
  logic [PosW-1:0]   pos;
  logic [PosW-1:0]   pos_base;
  logic [PosW-1:0]   pos_next;
  logic [PosW:0]     pos_inc;

  logic              acc;
  logic              acc_text;
  logic              key_we;
  logic              cfg_we;
  logic              res_free;

  logic              s1_valid;
  logic [BYTE_W-1:0] s1_byte;
  logic [SHIFT_W-1:0] key_rdata;

  logic              out_valid;
  logic [BYTE_W-1:0] out_byte;
  logic              out_letter;
  logic [BYTE_W-1:0] cipher;
  logic              letter;

  assign res_free = !out_valid || res.ready;
  assign req.ready = !s1_valid || res_free;
  assign acc = req.valid && req.ready;
  assign acc_text = acc && (req.req_type == REQ_TEXT);
  assign key_we = acc && (req.req_type == REQ_KEY) && (int'(req.key_slot) < KEY_DEPTH);

  always_comb begin
    if (key_length == '0) begin
      eff_len = KEY_LENGTH_RESET;
    end else if (int'(key_length) > KEY_DEPTH) begin
      eff_len = LEN_W'(EffMax);
    end else begin
      eff_len = key_length;
    end
  end

  assign pos_base = req.message_start ? '0 : pos;
  assign pos_inc = {1'b0, pos_base} + 1'b1;
  assign pos_next = ((LEN_W + 1)'(pos_inc) >= (LEN_W + 1)'(eff_len)) ? '0 : pos_inc[PosW-1:0];

  vbc_ram #(
    .WIDTH(SHIFT_W),
    .DEPTH(KEY_DEPTH)
  ) u_key_ram (
    .clk  (clk),
    .we   (key_we),
    .waddr(AddrW'(req.key_slot)),
    .wdata(key_shift_of(req.data_byte)),
    .re   (acc_text),
    .raddr(AddrW'(pos_base)),
    .rdata(key_rdata)
  );

  always_comb begin
    cipher = s1_byte;
    letter = 1'b0;
    if (s1_byte >= CHAR_LOWER_A && s1_byte <= CHAR_LOWER_Z) begin
      cipher = CHAR_LOWER_A + BYTE_W'(latin_add(SHIFT_W'(s1_byte - CHAR_LOWER_A), key_rdata));
      letter = 1'b1;
    end else if (s1_byte >= CHAR_UPPER_A && s1_byte <= CHAR_UPPER_Z) begin
      cipher = CHAR_UPPER_A + BYTE_W'(latin_add(SHIFT_W'(s1_byte - CHAR_UPPER_A), key_rdata));
      letter = 1'b1;
    end else if (s1_byte >= CYR_FIRST) begin
      cipher = {s1_byte[BYTE_W-1:SHIFT_W], s1_byte[SHIFT_W-1:0] + key_rdata};
      letter = 1'b1;
    end
  end

  assign cfg_we = psel && penable && pwrite && pready &&
                  (paddr[PADDR_W-1:2] == REG_KEY_LENGTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      key_length <= KEY_LENGTH_RESET;
      pos <= '0;
      s1_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        key_length <= pwdata[LEN_W-1:0];
      end
      if (acc_text) begin
        pos <= is_neutral(req.data_byte) ? pos_base : pos_next;
      end
      if (req.ready) begin
        s1_valid <= acc_text;
      end
      if (res_free) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc_text) begin
      s1_byte <= req.data_byte;
    end
    if (res_free) begin
      out_byte <= cipher;
      out_letter <= letter;
    end
  end

  assign res.valid = out_valid;
  assign res.cipher_byte = out_byte;
  assign res.was_letter = out_letter;

  assign pready = 1'b1;

  always_comb begin
    case (paddr[PADDR_W-1:2])
      REG_KEY_LENGTH: prdata = PDATA_W'(key_length);
      default: prdata = '0;
    endcase
  end

`ifndef SYNTHESIS
  a_pos_reset: assert property (@(posedge clk) rst |=> pos == '0)
    else $error("key position not cleared by reset");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !res_free |=> s1_valid && $stable(s1_byte))
    else $error("read stage lost a byte while the output was stalled");

  a_pos_wrap: assert property (@(posedge clk) disable iff (rst)
    acc_text && !is_neutral(req.data_byte) |=> (LEN_W + 1)'(pos) < (LEN_W + 1)'(eff_len))
    else $error("key position not below the key length after an advance");

  a_no_result_for_key: assert property (@(posedge clk) disable iff (rst)
    acc && (req.req_type == REQ_KEY) |=> !s1_valid)
    else $error("key write produced a result");
`endif

endmodule

`default_nettype wire
